/* rtl/bopd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bopd_pkg
// Shared types and constants for the byte-offset pixel decoder.
// ----------------------------------------------------------------------------
package bopd_pkg;

    // Special bytes of the stream.
    localparam logic [7:0]  MARKER_BYTE = 8'hD5;
    localparam logic [7:0]  ESCAPE_BYTE = 8'h80;
    localparam logic [31:0] ESCAPE16    = 32'h0000_8000;

    // Field widths fixed by the interface.
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned SUM_W       = 32;
    localparam int unsigned VALUE_W     = 31;
    localparam int unsigned COUNT_W     = 24;
    localparam int unsigned LIMIT_W     = 12;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 24;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_COUNT  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_LIMIT = 2'd1;

    // Reset values of the configuration registers.
    localparam logic [COUNT_W-1:0] PIXEL_COUNT_RESET  = 24'd1;
    localparam logic [LIMIT_W-1:0] HEADER_LIMIT_RESET = 12'd2000;

    // Status codes of a result item.
    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_NO_MARKER = 1'b1;

    // Result of the pixel accumulation for one delta.
    typedef struct packed {
        logic [SUM_W-1:0]   sum;
        logic [VALUE_W-1:0] value;
        logic [VALUE_W-1:0] max_value;
        logic               last;
    } pixel_res_t;

endpackage

/* rtl/bopd_pixel_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bopd_pixel_unit
// Adds one delta to the running sum, clamps the pixel at zero, updates the
// running maximum and advances the pixel counter with its last-pixel check.
// ----------------------------------------------------------------------------
module bopd_pixel_unit
    import bopd_pkg::*;
#(
    parameter int INDEX_WIDTH = 24
) (
    input  logic [SUM_W-1:0]       prev_sum,
    input  logic [SUM_W-1:0]       delta,
    input  logic [VALUE_W-1:0]     running_max,
    input  logic [INDEX_WIDTH-1:0] pixels_done,
    input  logic [INDEX_WIDTH-1:0] count_idx,
    output logic [INDEX_WIDTH-1:0] next_idx,
    output pixel_res_t             res
);

    logic [SUM_W-1:0]   sum;
    logic [VALUE_W-1:0] value;

    // The sum wraps at 32 bits; a negative sum shows as zero.
    always_comb begin
        sum   = prev_sum + delta;
        value = sum[SUM_W-1] ? '0 : sum[VALUE_W-1:0];
    end

    assign next_idx = pixels_done + {{(INDEX_WIDTH-1){1'b0}}, 1'b1};

    always_comb begin
        res.sum       = sum;
        res.value     = value;
        res.max_value = (value > running_max) ? value : running_max;
        res.last      = (next_idx == count_idx);
    end

endmodule

/* rtl/byte_offset_pixel_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_offset_pixel_decoder
// Skips the file header up to the binary start marker, then decodes
// byte-offset deltas into clamped pixel counts with index and running maximum.
// ----------------------------------------------------------------------------
//  Channel   Direction  Ports                                    Moves
//  s_        in         s_in_byte, s_frame_start                 one file byte
//  m_        out        m_pixel_value .. m_status                pixel or error
//  cfg_      in         cfg_index, cfg_data                      register write
//
//  A new byte is accepted in every cycle unless a held result is not drained.
//  The decoder state and the result register are updated at the same edge,
//  so a result appears in the cycle after the byte that completes it.
//  A byte is accepted while the result register is empty or being drained.
//  Reset restores pixel_count = 1, header_limit = 2000 and header search.
// ----------------------------------------------------------------------------
module byte_offset_pixel_decoder
    import bopd_pkg::*;
#(
    parameter int INDEX_WIDTH = 24
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [7:0]             s_in_byte,
    input  logic                   s_frame_start,

    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [30:0]            m_pixel_value,
    output logic [23:0]            m_pixel_index,
    output logic [30:0]            m_max_value,
    output logic                   m_last_pixel,
    output logic                   m_status,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_DATA,
        PH_ESC16,
        PH_ESC32,
        PH_DONE,
        PH_ERROR
    } phase_t;

    // Configuration registers.
    logic [COUNT_W-1:0]     pixel_count_reg;
    logic [LIMIT_W-1:0]     header_limit_reg;

    // Decoder state.
    phase_t                 phase_reg, phase_next;
    logic [LIMIT_W-1:0]     header_seen_reg, header_seen_next;
    logic [2:0]             esc_left_reg, esc_left_next;
    logic [SUM_W-1:0]       collect_reg, collect_next;
    logic [SUM_W-1:0]       prev_sum_reg, prev_sum_next;
    logic [INDEX_WIDTH-1:0] pixels_done_reg, pixels_done_next;
    logic [VALUE_W-1:0]     run_max_reg, run_max_next;

    // Result register.
    logic                   m_valid_reg;
    logic [VALUE_W-1:0]     pixel_value_reg;
    logic [COUNT_W-1:0]     pixel_index_reg;
    logic [VALUE_W-1:0]     max_value_reg;
    logic                   last_pixel_reg;
    logic                   status_reg;

    // State seen by the current item, after an optional frame restart.
    phase_t                 cur_phase;
    logic [LIMIT_W-1:0]     cur_seen;
    logic [2:0]             cur_left;
    logic [SUM_W-1:0]       cur_collect;
    logic [SUM_W-1:0]       cur_sum;
    logic [INDEX_WIDTH-1:0] cur_done;
    logic [VALUE_W-1:0]     cur_max;

    logic                   in_fire;
    logic [LIMIT_W-1:0]     limit_eff;
    logic [LIMIT_W-1:0]     seen_inc;
    logic [1:0]             byte_pos;
    logic [SUM_W-1:0]       gathered;
    logic [SUM_W-1:0]       delta;
    logic                   emit_pixel;
    logic                   emit_error;
    logic [INDEX_WIDTH-1:0] count_idx;
    logic [INDEX_WIDTH-1:0] next_idx;
    logic [COUNT_W-1:0]     index_out;
    pixel_res_t             pix;

    assign s_ready   = !m_valid_reg || m_ready;
    assign in_fire   = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // Pixel count seen in the counter's width, and the counter seen in 24 bits.
    generate
        if (INDEX_WIDTH >= COUNT_W) begin : g_wide_idx
            assign count_idx = {{(INDEX_WIDTH-COUNT_W){1'b0}}, pixel_count_reg};
            assign index_out = cur_done[COUNT_W-1:0];
        end else begin : g_narrow_idx
            assign count_idx = pixel_count_reg[INDEX_WIDTH-1:0];
            assign index_out = {{(COUNT_W-INDEX_WIDTH){1'b0}}, cur_done};
        end
    endgenerate

    // A frame start returns the state to its reset values for this byte.
    always_comb begin
        if (s_frame_start) begin
            cur_phase   = PH_HEADER;
            cur_seen    = '0;
            cur_left    = '0;
            cur_collect = '0;
            cur_sum     = '0;
            cur_done    = '0;
            cur_max     = '0;
        end else begin
            cur_phase   = phase_reg;
            cur_seen    = header_seen_reg;
            cur_left    = esc_left_reg;
            cur_collect = collect_reg;
            cur_sum     = prev_sum_reg;
            cur_done    = pixels_done_reg;
            cur_max     = run_max_reg;
        end
    end

    // Header search bookkeeping; a zero limit acts as a limit of one.
    assign limit_eff = (header_limit_reg == '0) ? LIMIT_W'(1) : header_limit_reg;
    assign seen_inc  = cur_seen + LIMIT_W'(1);

    // Byte lane of an escape byte, counted from the low end.
    always_comb begin
        if (cur_phase == PH_ESC16) begin
            byte_pos = {1'b0, cur_left[0]};
        end else begin
            byte_pos = 2'(3'd4 - cur_left);
        end
        gathered = cur_collect | (SUM_W'(s_in_byte) << {byte_pos, 3'b000});
    end

    bopd_pixel_unit #(
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_pixel (
        .prev_sum    (cur_sum),
        .delta       (delta),
        .running_max (cur_max),
        .pixels_done (cur_done),
        .count_idx   (count_idx),
        .next_idx    (next_idx),
        .res         (pix)
    );

    // Next-state logic for one byte.
    always_comb begin
        phase_next       = cur_phase;
        header_seen_next = cur_seen;
        esc_left_next    = cur_left;
        collect_next     = cur_collect;
        prev_sum_next    = cur_sum;
        pixels_done_next = cur_done;
        run_max_next     = cur_max;
        delta            = {{(SUM_W-BYTE_W){s_in_byte[7]}}, s_in_byte};
        emit_pixel       = 1'b0;
        emit_error       = 1'b0;

        unique case (cur_phase)
            PH_HEADER: begin
                if (s_in_byte == MARKER_BYTE) begin
                    phase_next = PH_DATA;
                end else begin
                    header_seen_next = seen_inc;
                    if (seen_inc >= limit_eff) begin
                        phase_next = PH_ERROR;
                        emit_error = 1'b1;
                    end
                end
            end
            PH_DATA: begin
                if (s_in_byte == ESCAPE_BYTE) begin
                    phase_next    = PH_ESC16;
                    esc_left_next = 3'd2;
                    collect_next  = '0;
                end else begin
                    emit_pixel = 1'b1;
                end
            end
            PH_ESC16: begin
                collect_next  = gathered;
                esc_left_next = cur_left - 3'd1;
                delta         = {{16{gathered[15]}}, gathered[15:0]};
                if (cur_left == 3'd1) begin
                    if (gathered == ESCAPE16) begin
                        phase_next    = PH_ESC32;
                        esc_left_next = 3'd4;
                        collect_next  = '0;
                    end else begin
                        emit_pixel = 1'b1;
                    end
                end
            end
            PH_ESC32: begin
                collect_next  = gathered;
                esc_left_next = cur_left - 3'd1;
                delta         = gathered;
                if (cur_left == 3'd1) begin
                    emit_pixel = 1'b1;
                end
            end
            default: begin
                // Frame done or marker missing: bytes are dropped.
            end
        endcase

        if (emit_pixel) begin
            prev_sum_next    = pix.sum;
            run_max_next     = pix.max_value;
            pixels_done_next = next_idx;
            phase_next       = pix.last ? PH_DONE : PH_DATA;
        end
    end

    // Configuration, decoder state and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixel_count_reg  <= PIXEL_COUNT_RESET;
            header_limit_reg <= HEADER_LIMIT_RESET;
            phase_reg        <= PH_HEADER;
            header_seen_reg  <= '0;
            esc_left_reg     <= '0;
            collect_reg      <= '0;
            prev_sum_reg     <= '0;
            pixels_done_reg  <= '0;
            run_max_reg      <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_PIXEL_COUNT:  pixel_count_reg  <= cfg_data[COUNT_W-1:0];
                    CFG_HEADER_LIMIT: header_limit_reg <= cfg_data[LIMIT_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (in_fire) begin
                phase_reg       <= phase_next;
                header_seen_reg <= header_seen_next;
                esc_left_reg    <= esc_left_next;
                collect_reg     <= collect_next;
                prev_sum_reg    <= prev_sum_next;
                pixels_done_reg <= pixels_done_next;
                run_max_reg     <= run_max_next;
            end

            if (in_fire && (emit_pixel || emit_error)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload; no reset needed.
    always_ff @(posedge aclk) begin
        if (in_fire && emit_pixel) begin
            pixel_value_reg <= pix.value;
            pixel_index_reg <= index_out;
            max_value_reg   <= pix.max_value;
            last_pixel_reg  <= pix.last;
            status_reg      <= STATUS_OK;
        end else if (in_fire && emit_error) begin
            pixel_value_reg <= '0;
            pixel_index_reg <= '0;
            max_value_reg   <= '0;
            last_pixel_reg  <= 1'b0;
            status_reg      <= STATUS_NO_MARKER;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_pixel_value = pixel_value_reg;
    assign m_pixel_index = pixel_index_reg;
    assign m_max_value   = max_value_reg;
    assign m_last_pixel  = last_pixel_reg;
    assign m_status      = status_reg;

endmodule
